[rtl/sfcd_pkg.sv]
// Package for the sensor frame CRC decoder: frame constants, group phase
// type, step and result structs, and the CRC-8 byte update function.
// No dependencies.
package sfcd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [15:0] BAD_WORD   = 16'hEEEE;
    localparam int          NUM_SLOTS  = 5;
    localparam int          SLOT_W     = $clog2(NUM_SLOTS);
    localparam logic [3:0]  LAST_GROUP = 4'd9;
    localparam logic [3:0]  FIRST_SKIP = 4'd4;
    localparam logic [SLOT_W-1:0] SIZE_SLOT = SLOT_W'(4);

    // Position of a byte inside its three-byte group
    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } phase_t;

    // What the current request does to the checked-word store
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       word;
        logic              bad;
        logic              last;
    } step_t;

    typedef struct packed {
        logic [15:0] pm1_mass;
        logic [15:0] pm2_5_mass;
        logic [15:0] pm4_mass;
        logic [15:0] pm10_mass;
        logic [15:0] typical_size;
        logic [4:0]  error_mask;
        logic        frame_ok;
    } result_t;

    // CRC-8 over one byte, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/sfcd_in_if.sv]
// Handshake interface for received frame bytes.
// Depends on nothing.
interface sfcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

[rtl/sfcd_out_if.sv]
// Handshake interface for decoded frame results.
// Depends on nothing.
interface sfcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pm1_mass;
    logic [15:0] pm2_5_mass;
    logic [15:0] pm4_mass;
    logic [15:0] pm10_mass;
    logic [15:0] typical_size;
    logic [4:0]  error_mask;
    logic        frame_ok;

    modport source (output valid, output pm1_mass, output pm2_5_mass, output pm4_mass,
                    output pm10_mass, output typical_size, output error_mask,
                    output frame_ok, input ready);
    modport sink   (input valid, input pm1_mass, input pm2_5_mass, input pm4_mass,
                    input pm10_mass, input typical_size, input error_mask,
                    input frame_ok, output ready);
endinterface

[rtl/sfcd_group_track.sv]
// Frame position tracking and per-group CRC check for the frame decoder.
// Depends on sfcd_pkg.
module sfcd_group_track
    import sfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output step_t       step
);

    phase_t     phase_reg, phase_next, phase_cur;
    logic [3:0] group_reg, group_next, group_cur;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] crc_reg, crc_next;

    // Decode position of the current byte and its effect
    always_comb
    begin
        phase_cur  = frame_start ? PH_HIGH : phase_reg;
        group_cur  = frame_start ? 4'd0 : group_reg;
        phase_next = phase_cur;
        group_next = group_cur;
        high_next  = high_reg;
        low_next   = low_reg;
        crc_next   = crc_reg;
        step       = '0;
        step.word  = {high_reg, low_reg};
        step.bad   = (crc_reg != rx_byte);
        step.slot  = (group_cur == LAST_GROUP) ? SIZE_SLOT : SLOT_W'(group_cur);
        case (phase_cur)
            PH_HIGH:
            begin
                high_next  = rx_byte;
                crc_next   = crc8_byte(CRC_INIT, rx_byte);
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                low_next   = rx_byte;
                crc_next   = crc8_byte(crc_reg, rx_byte);
                phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                step.wr    = (group_cur < FIRST_SKIP) || (group_cur == LAST_GROUP);
                step.last  = (group_cur == LAST_GROUP);
                phase_next = PH_HIGH;
                group_next = step.last ? 4'd0 : group_cur + 4'd1;
            end
            default:
            begin
                phase_next = PH_HIGH;
                group_next = 4'd0;
            end
        endcase
    end

    // Advance position when the request is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HIGH;
            group_reg <= 4'd0;
            high_reg  <= 8'd0;
            low_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            group_reg <= group_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

[rtl/sensor_frame_crc_decoder.sv]
// Top level of the sensor frame CRC decoder: input register, checked-word
// store and result register. Depends on sfcd_pkg, sfcd_in_if, sfcd_out_if
// and sfcd_group_track.
//
//   channel | dir | payload                                     | requests
//   rx_ch   | in  | rx_byte, frame_start                        | one per frame byte
//   res_ch  | out | five words, error_mask, frame_ok            | one per 30 bytes
//
// One request is taken every cycle while no frame end is stalled; each byte passes
// the input register and the CRC/update logic; a frame end loads the result register.
// Group counters track position; the CRC advances one byte a cycle unless stalled.
// Reset clears position and both valid flags, inits the CRC; stored words read 0xEEEE.
// A stalled result holds in its register; bytes keep flowing until a second
// frame end meets a still-waiting result.
module sensor_frame_crc_decoder
    import sfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sfcd_in_if.sink    rx_ch,
    sfcd_out_if.source res_ch
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;
    logic        advance;
    step_t       step;

    logic [15:0] value_reg [NUM_SLOTS];
    logic [15:0] value_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] flags_reg, flags_next;

    logic        res_valid_reg, res_valid_next;
    result_t     res_reg;
    result_t     res_next;

    sfcd_group_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .step        (step)
    );

    // Process the held byte unless its result would meet a full result register
    assign advance     = s1_valid_reg && (!step.last || !res_valid_reg || res_ch.ready);
    assign rx_ch.ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_ch.valid && rx_ch.ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    // Hold the accepted request in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ch.valid && rx_ch.ready)
        begin
            s1_byte_reg  <= rx_ch.rx_byte;
            s1_start_reg <= rx_ch.frame_start;
        end
    end

    // Update the checked-word store
    always_comb
    begin
        flags_next = flags_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
            value_next[i] = value_reg[i];
        if (advance && step.wr)
        begin
            value_next[step.slot] = step.bad ? BAD_WORD : step.word;
            flags_next[step.slot] = step.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                value_reg[i] <= BAD_WORD;
        end
        else
        begin
            flags_reg <= flags_next;
            for (int i = 0; i < NUM_SLOTS; i++)
                value_reg[i] <= value_next[i];
        end
    end

    // Build the result from the updated store
    always_comb
    begin
        res_next.pm1_mass     = value_next[0];
        res_next.pm2_5_mass   = value_next[1];
        res_next.pm4_mass     = value_next[2];
        res_next.pm10_mass    = value_next[3];
        res_next.typical_size = value_next[SIZE_SLOT];
        res_next.error_mask   = flags_next;
        res_next.frame_ok     = (flags_next == '0);

        res_valid_next = res_valid_reg;
        if (advance && step.last)
            res_valid_next = 1'b1;
        else if (res_ch.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.last)
            res_reg <= res_next;
    end

    assign res_ch.valid        = res_valid_reg;
    assign res_ch.pm1_mass     = res_reg.pm1_mass;
    assign res_ch.pm2_5_mass   = res_reg.pm2_5_mass;
    assign res_ch.pm4_mass     = res_reg.pm4_mass;
    assign res_ch.pm10_mass    = res_reg.pm10_mass;
    assign res_ch.typical_size = res_reg.typical_size;
    assign res_ch.error_mask   = res_reg.error_mask;
    assign res_ch.frame_ok     = res_reg.frame_ok;

    // Frame-ok agrees with the error mask
    a_ok_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.frame_ok == (res_reg.error_mask == 5'd0)))
        else $error("frame_ok disagrees with error_mask");

    // A failed typical-size word reads as the bad-word marker
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.error_mask[4]) |-> (res_reg.typical_size == BAD_WORD))
        else $error("failed word not replaced");

    // Processing a frame end always loads the result register
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step.last) |=> res_valid_reg)
        else $error("frame end lost");

    // A held byte that cannot advance stays in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("stalled byte dropped");

endmodule
